/* hw/rtl/sfr_pkg.sv */
// shared types and constants of the serial frame receiver
`timescale 1ns / 1ps

package sfr_pkg;

  // payload bytes per frame including the length byte position
  localparam int unsigned BUFFER_DEPTH = 64;
  localparam int unsigned CountWidth   = 9;

  localparam logic [15:0] HeaderReset       = 16'h5AA5;
  localparam logic [7:0]  RxTimeoutReset    = 8'd10;
  localparam logic [7:0]  ReplyTimeoutReset = 8'd50;

  typedef enum logic [1:0] {
    ModeByte     = 2'd0,
    ModeTick     = 2'd1,
    ModeSend     = 2'd2,
    ModeConsumed = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PhaseHdrHi  = 2'd0,
    PhaseHdrLo  = 2'd1,
    PhaseLength = 2'd2,
    PhaseData   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RxIdle     = 2'd0,
    RxBusy     = 2'd1,
    RxError    = 2'd2,
    RxComplete = 2'd3
  } rx_status_e;

  typedef enum logic [1:0] {
    TxIdle     = 2'd0,
    TxWaiting  = 2'd1,
    TxReplied  = 2'd2,
    TxTimedOut = 2'd3
  } tx_status_e;

  typedef enum logic [1:0] {
    CfgHeader       = 2'd0,
    CfgRxTimeout    = 2'd1,
    CfgReplyTimeout = 2'd2,
    CfgUnused       = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [15:0] header_word;
    logic [7:0]  receive_timeout;
    logic [7:0]  response_timeout;
  } cfg_t;

  typedef struct packed {
    phase_e                  parse_phase;
    logic [CountWidth-1:0]   byte_count;
    logic [7:0]              frame_length;
    rx_status_e              receive_status;
    logic [7:0]              receive_timer;
    tx_status_e              reply_status;
    logic [7:0]              reply_timer;
  } state_t;

  typedef struct packed {
    logic       frame_done;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       payload_valid;
    tx_status_e send_status;
    rx_status_e rec_status;
  } result_t;

endpackage

/* hw/rtl/sfr_next.sv */
// next-state and result logic for one beat of the frame receiver
`timescale 1ns / 1ps

module sfr_next (
  input  sfr_pkg::cfg_t    cfg_i,
  input  sfr_pkg::state_t  state_i,
  input  sfr_pkg::mode_e   mode_i,
  input  logic [7:0]       data_byte_i,
  output sfr_pkg::state_t  state_o,
  output sfr_pkg::result_t result_o
);
  import sfr_pkg::*;

  localparam logic [CountWidth-1:0] DepthLimit = CountWidth'(BUFFER_DEPTH);

  state_t                s;
  result_t               r;
  logic [CountWidth-1:0] count_inc;
  logic [7:0]            rx_timer_inc;
  logic [7:0]            tx_timer_inc;

  always_comb begin
    s            = state_i;
    r            = '0;
    count_inc    = '0;
    rx_timer_inc = '0;
    tx_timer_inc = '0;

    unique case (mode_i)
      ModeByte: begin
        // a byte after an error restarts the parser first
        if (s.receive_status == RxError) begin
          s.byte_count     = '0;
          s.parse_phase    = PhaseHdrHi;
          s.receive_status = RxIdle;
        end
        unique case (s.parse_phase)
          PhaseHdrHi: begin
            if (data_byte_i == cfg_i.header_word[15:8]) begin
              s.parse_phase    = PhaseHdrLo;
              s.receive_status = RxBusy;
            end
          end
          PhaseHdrLo: begin
            if (data_byte_i == cfg_i.header_word[7:0]) begin
              s.parse_phase = PhaseLength;
            end else begin
              s.parse_phase    = PhaseHdrHi;
              s.receive_status = RxIdle;
            end
          end
          PhaseLength: begin
            s.frame_length  = data_byte_i;
            s.parse_phase   = PhaseData;
            r.payload_valid = 1'b1;
            r.payload_byte  = data_byte_i;
          end
          default: begin
            count_inc    = s.byte_count + 1'b1;
            s.byte_count = count_inc;
            if (count_inc >= DepthLimit) begin
              s.receive_status = RxError;
            end else begin
              r.payload_valid = 1'b1;
              r.payload_index = count_inc[7:0];
              r.payload_byte  = data_byte_i;
              if ({1'b0, s.frame_length} <= count_inc) begin
                s.parse_phase    = PhaseHdrHi;
                s.byte_count     = '0;
                s.receive_status = RxComplete;
                r.frame_done     = 1'b1;
                if (s.reply_status == TxWaiting) s.reply_status = TxReplied;
              end
            end
          end
        endcase
      end
      ModeTick: begin
        if (cfg_i.receive_timeout != '0 && s.receive_status == RxBusy) begin
          rx_timer_inc    = s.receive_timer + 1'b1;
          s.receive_timer = rx_timer_inc;
          if (rx_timer_inc >= cfg_i.receive_timeout) begin
            s.receive_status = RxError;
            s.receive_timer  = '0;
          end
        end else begin
          s.receive_timer = '0;
        end
        if (cfg_i.response_timeout != '0 && s.reply_status == TxWaiting) begin
          tx_timer_inc  = s.reply_timer + 1'b1;
          s.reply_timer = tx_timer_inc;
          if (tx_timer_inc >= cfg_i.response_timeout) begin
            s.reply_status = TxTimedOut;
            s.reply_timer  = '0;
          end
        end else begin
          s.reply_timer = '0;
        end
      end
      ModeSend: begin
        s.reply_timer  = '0;
        s.reply_status = (cfg_i.response_timeout != '0) ? TxWaiting : TxReplied;
      end
      default: begin
        if (s.receive_status == RxComplete) s.receive_status = RxIdle;
      end
    endcase

    r.rec_status  = s.receive_status;
    r.send_status = s.reply_status;
  end

  assign state_o  = s;
  assign result_o = r;

endmodule

/* hw/rtl/serial_frame_receiver_with_timeout.sv */
// top level of the header/length serial frame receiver with timeouts
// latency: a result beat is offered the cycle after its input beat is accepted
// throughput: one input beat per cycle; the output register frees in the same
//   cycle it is taken, so s_axis_tready follows m_axis_tready when full
// reset: parser, timers and status clear, registers return to their defaults
// config writes are always ready and take effect on the next accepted beat
`timescale 1ns / 1ps

module serial_frame_receiver_with_timeout (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] rec_status, [3:2] send_status, [11:4] payload_index,
  // [19:12] payload_byte, [23:20] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] payload_valid
  output logic        m_axis_tlast    // frame_done
);
  import sfr_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t result_q, result_d;
  logic    out_valid_q;
  logic    in_accept;
  mode_e   mode;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign mode          = mode_e'(s_axis_tuser);

  sfr_next u_next (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .mode_i      (mode),
    .data_byte_i (s_axis_tdata),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_word      <= HeaderReset;
      cfg_q.receive_timeout  <= RxTimeoutReset;
      cfg_q.response_timeout <= ReplyTimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgHeader:       cfg_q.header_word      <= cfg_data_i;
        CfgRxTimeout:    cfg_q.receive_timeout  <= cfg_data_i[7:0];
        CfgReplyTimeout: cfg_q.response_timeout <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.parse_phase    <= PhaseHdrHi;
      state_q.byte_count     <= '0;
      state_q.frame_length   <= '0;
      state_q.receive_status <= RxIdle;
      state_q.receive_timer  <= '0;
      state_q.reply_status   <= TxIdle;
      state_q.reply_timer    <= '0;
      out_valid_q            <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, result_q.payload_byte, result_q.payload_index,
                          result_q.send_status, result_q.rec_status};
  assign m_axis_tuser  = result_q.payload_valid;
  assign m_axis_tlast  = result_q.frame_done;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.byte_count <= CountWidth'(BUFFER_DEPTH))
    else $error("byte count beyond buffer depth");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.parse_phase != PhaseData |-> state_q.byte_count == '0)
    else $error("byte count nonzero outside payload phase");

  a_done_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.frame_done |->
      result_q.payload_valid && result_q.rec_status == RxComplete)
    else $error("frame done without a stored byte");
`endif

endmodule

/* test/testbench.sv */
// self-checking stream testbench for the serial frame receiver with timeouts
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned HoldOffAfter  = 40;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] data;
  } link_item_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] data_byte
  logic [1:0]  s_axis_tuser  = '0;  // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [1:0] rec_status, [3:2] send_status, [11:4] payload_index,
  // [19:12] payload_byte, [23:20] zero
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;        // [0] payload_valid
  logic        m_axis_tlast;        // frame_done

  link_item_t pending_items[$];
  result_t    awaited_reports[$];
  int unsigned planned_items = 0;
  int unsigned fail_count    = 0;
  int unsigned results_seen  = 0;
  int unsigned stall_left    = 0;
  int unsigned stalled_cycles = 0;
  logic        steady_flow   = 1'b0;

  // receiver state as the testbench sees it
  logic [15:0]           hdr_cfg    = HeaderReset;
  logic [7:0]            rx_limit   = RxTimeoutReset;
  logic [7:0]            tx_limit   = ReplyTimeoutReset;
  phase_e                parse_q    = PhaseHdrHi;
  logic [CountWidth-1:0] count_q    = '0;
  logic [7:0]            length_q   = '0;
  rx_status_e            rx_q       = RxIdle;
  logic [7:0]            rx_timer_q = '0;
  tx_status_e            tx_q       = TxIdle;
  logic [7:0]            tx_timer_q = '0;

  serial_frame_receiver_with_timeout i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t parse_link_item(mode_e mode, logic [7:0] rx_byte);
    result_t report;
    report = '0;
    case (mode)
      ModeByte: begin
        // a byte after an error restarts the parser before being parsed
        if (rx_q == RxError) begin
          count_q = '0;
          parse_q = PhaseHdrHi;
          rx_q    = RxIdle;
        end
        case (parse_q)
          PhaseHdrHi: begin
            if (rx_byte == hdr_cfg[15:8]) begin
              parse_q = PhaseHdrLo;
              rx_q    = RxBusy;
            end
          end
          PhaseHdrLo: begin
            if (rx_byte == hdr_cfg[7:0]) begin
              parse_q = PhaseLength;
            end else begin
              parse_q = PhaseHdrHi;
              rx_q    = RxIdle;
            end
          end
          PhaseLength: begin
            length_q              = rx_byte;
            parse_q               = PhaseData;
            report.payload_valid  = 1'b1;
            report.payload_byte   = rx_byte;
          end
          default: begin
            count_q = count_q + 1'b1;
            if (count_q >= BUFFER_DEPTH) begin
              rx_q = RxError;
            end else begin
              report.payload_valid = 1'b1;
              report.payload_index = count_q[7:0];
              report.payload_byte  = rx_byte;
              if (length_q <= count_q) begin
                parse_q           = PhaseHdrHi;
                count_q           = '0;
                rx_q              = RxComplete;
                report.frame_done = 1'b1;
                if (tx_q == TxWaiting) tx_q = TxReplied;
              end
            end
          end
        endcase
      end
      ModeTick: begin
        if (rx_limit != 0 && rx_q == RxBusy) begin
          rx_timer_q = rx_timer_q + 1'b1;
          if (rx_timer_q >= rx_limit) begin
            rx_q       = RxError;
            rx_timer_q = '0;
          end
        end else begin
          rx_timer_q = '0;
        end
        if (tx_limit != 0 && tx_q == TxWaiting) begin
          tx_timer_q = tx_timer_q + 1'b1;
          if (tx_timer_q >= tx_limit) begin
            tx_q       = TxTimedOut;
            tx_timer_q = '0;
          end
        end else begin
          tx_timer_q = '0;
        end
      end
      ModeSend: begin
        tx_timer_q = '0;
        tx_q       = (tx_limit != 0) ? TxWaiting : TxReplied;
      end
      default: begin
        if (rx_q == RxComplete) rx_q = RxIdle;
      end
    endcase
    report.rec_status  = rx_q;
    report.send_status = tx_q;
    return report;
  endfunction

  function automatic void field_check(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_report(result_t got, logic [3:0] pad);
    result_t want;
    want = awaited_reports.pop_front();
    field_check("rec_status", want.rec_status, got.rec_status);
    field_check("send_status", want.send_status, got.send_status);
    field_check("payload_valid", want.payload_valid, got.payload_valid);
    field_check("payload_index", want.payload_index, got.payload_index);
    field_check("payload_byte", want.payload_byte, got.payload_byte);
    field_check("frame_done", want.frame_done, got.frame_done);
    field_check("tdata padding", 0, pad);
  endfunction

  // sender: offers queued items and predicts each accepted beat
  always @(posedge clk_i) begin : drive_link
    link_item_t next_item;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_e'(cfg_index_i))
          CfgHeader:       hdr_cfg  = cfg_data_i;
          CfgRxTimeout:    rx_limit = cfg_data_i[7:0];
          CfgReplyTimeout: tx_limit = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_reports.push_back(parse_link_item(mode_e'(s_axis_tuser), s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 20)) begin
          next_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.data;
          s_axis_tuser  <= next_item.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks result beats, stalls at random and once for a long stretch
  always @(posedge clk_i) begin : watch_reports
    result_t got_beat;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time,
                   m_axis_tdata);
          fail_count++;
        end else begin
          got_beat               = '0;
          got_beat.rec_status    = rx_status_e'(m_axis_tdata[1:0]);
          got_beat.send_status   = tx_status_e'(m_axis_tdata[3:2]);
          got_beat.payload_index = m_axis_tdata[11:4];
          got_beat.payload_byte  = m_axis_tdata[19:12];
          got_beat.payload_valid = m_axis_tuser;
          got_beat.frame_done    = m_axis_tlast;
          check_report(got_beat, m_axis_tdata[23:20]);
        end
        results_seen++;
        if (results_seen == HoldOffAfter) stall_left = HoldOffCycles;
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic push_item(mode_e mode, logic [7:0] value);
    link_item_t item;
    item.mode = mode;
    item.data = value;
    pending_items.push_back(item);
    planned_items++;
  endtask

  task automatic push_tick();
    push_item(ModeTick, 8'($urandom_range(0, 255)));
  endtask

  // header, length byte and payload; ticks may fall between bytes
  task automatic queue_frame(logic [15:0] hdr, logic [7:0] len, int unsigned n_bytes);
    push_item(ModeByte, hdr[15:8]);
    push_item(ModeByte, hdr[7:0]);
    push_item(ModeByte, len);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 99) < 10) push_tick();
      push_item(ModeByte, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_traffic(logic [15:0] hdr, int unsigned n_items, bit with_overflow);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    int unsigned n_bytes;
    logic [7:0]  lo_byte;
    target = planned_items + n_items;
    if (with_overflow) queue_frame(hdr, 8'($urandom_range(64, 255)), BUFFER_DEPTH);
    while (planned_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 255) : $urandom_range(0, 8);
        n_bytes = (len == 0) ? 1 : len;
        if (n_bytes > BUFFER_DEPTH) n_bytes = BUFFER_DEPTH;
        // truncated frames are left for the receive timer or the next header
        if ($urandom_range(0, 9) == 0) n_bytes = $urandom_range(0, n_bytes - 1);
        queue_frame(hdr, 8'(len), n_bytes);
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 12)) push_tick();
      end else if (pick < 75) begin
        push_item(ModeSend, 8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        push_item(ModeConsumed, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        lo_byte = 8'($urandom_range(0, 255));
        if (lo_byte == hdr[7:0]) lo_byte = ~lo_byte;
        push_item(ModeByte, hdr[15:8]);
        push_item(ModeByte, lo_byte);
      end else begin
        push_item(ModeByte, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // every item gives one result, so an empty store means the block is idle
  task automatic wait_idle();
    while (pending_items.size() != 0 || s_axis_tvalid || awaited_reports.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] hdr, logic [7:0] rx_ticks, logic [7:0] tx_ticks);
    write_reg(CfgHeader, hdr);
    write_reg(CfgRxTimeout, {8'h00, rx_ticks});
    write_reg(CfgReplyTimeout, {8'h00, tx_ticks});
  endtask

  initial begin : run_phases
    logic [7:0]  rep;
    logic [15:0] hdr;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults straight out of reset
    push_item(ModeByte, 8'h00);
    push_item(ModeByte, 8'hFF);
    push_item(ModeConsumed, 8'h00);
    push_item(ModeSend, 8'hFF);
    push_tick();
    push_item(ModeByte, HeaderReset[15:8]);
    push_item(ModeByte, 8'h00);                   // wrong second header byte
    queue_frame(HeaderReset, 8'd0, 0);
    push_item(ModeByte, 8'hFF);                   // zero length completes here
    push_item(ModeConsumed, 8'hFF);
    push_item(ModeConsumed, 8'h00);
    queue_frame(HeaderReset, 8'd2, 2);
    push_item(ModeByte, HeaderReset[15:8]);       // new frame while one is unconsumed
    push_item(ModeByte, HeaderReset[7:0]);
    push_item(ModeByte, 8'd1);
    push_item(ModeByte, 8'hAA);
    wait_idle();

    // directed: shortest timeouts
    set_regs(HeaderReset, 8'd1, 8'd1);
    push_item(ModeByte, HeaderReset[15:8]);
    push_tick();
    push_item(ModeByte, HeaderReset[15:8]);       // clears the error and starts again
    push_item(ModeSend, 8'h00);
    push_tick();
    push_item(ModeByte, 8'h33);
    wait_idle();

    set_regs(HeaderReset, RxTimeoutReset, ReplyTimeoutReset);
    queue_traffic(HeaderReset, 145, 1'b1);
    push_item(ModeSend, 8'h00);                   // left awaiting a reply into the next phase
    wait_idle();

    write_reg(CfgUnused, 16'hFFFF);
    set_regs(16'h0000, 8'd0, 8'd0);
    steady_flow = 1'b1;
    queue_traffic(16'h0000, 145, 1'b0);
    wait_idle();
    steady_flow = 1'b0;

    set_regs(16'hFFFF, 8'd255, 8'd255);
    queue_traffic(16'hFFFF, 145, 1'b1);
    wait_idle();

    hdr = 16'($urandom_range(0, 65535));
    set_regs(hdr, 8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)));
    queue_traffic(hdr, 145, 1'b0);
    wait_idle();

    // both header bytes equal
    rep = 8'($urandom_range(0, 255));
    set_regs({rep, rep}, 8'd2, 8'd5);
    queue_traffic({rep, rep}, 145, 1'b1);
    wait_idle();

    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && awaited_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
